/* rtl/core/dett_pkg.sv */
// Shared types and codes for the delayed event timer table.
package dett_pkg;

    localparam int MAX_EVENTS_DEF = 16;

    localparam int KIND_W    = 4;
    localparam int SESSION_W = 32;
    localparam int DELAY_W   = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SCHEDULE   = 3'd0,
        OP_RESCHEDULE = 3'd1,
        OP_CANCEL     = 3'd2,
        OP_TICK       = 3'd3,
        OP_DEQUEUE    = 3'd4
    } op_t;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE = '0;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SESSION_W-1:0] session;
        logic [DELAY_W-1:0]   delay;
    } entry_t;

endpackage

/* rtl/core/dett_req_if.sv */
// Request channel of the timer table: handshake and command fields.
interface dett_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [dett_pkg::OP_W-1:0]            operation;
    logic [dett_pkg::KIND_W-1:0]          event_kind;
    logic [dett_pkg::SESSION_W-1:0]       session_number;
    logic [dett_pkg::DELAY_W-1:0]         delay_amount;
    logic [dett_pkg::DELAY_W-1:0]         elapsed_amount;

    modport source (
        output valid, operation, event_kind, session_number, delay_amount, elapsed_amount,
        input  ready
    );
    modport sink (
        input  valid, operation, event_kind, session_number, delay_amount, elapsed_amount,
        output ready
    );
endinterface

/* rtl/core/dett_rsp_if.sv */
// Response channel of the timer table: handshake and result fields.
interface dett_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [dett_pkg::STATUS_W-1:0]        status;
    logic                                 ready_valid;
    logic [dett_pkg::KIND_W-1:0]          ready_kind;
    logic [dett_pkg::SESSION_W-1:0]       ready_session;

    modport source (
        output valid, status, ready_valid, ready_kind, ready_session,
        input  ready
    );
    modport sink (
        input  valid, status, ready_valid, ready_kind, ready_session,
        output ready
    );
endinterface

/* rtl/core/dett_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dett_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/delayed_event_timer_table.sv */
// Delayed event timer table: ordered list of pending events in one RAM.
//
// Usage: commands come in on req (valid/ready), one result per command leaves on rsp.
// The table is a RAM of MAX_EVENTS entries {kind, session, delay} plus an entry count.
// Schedule writes the tail entry directly and goes straight to the finish state, from
// which the result goes into the output register.
// Reschedule, cancel, tick and dequeue walk the table once through the RAM read
// port: one entry read per cycle, the modified or surviving entry written back in the
// next cycle at the compaction pointer. The walk over the single RAM port makes such a
// command take longer the more entries the table holds. One command is in work at a
// time; req.ready is high only in the idle state, so a new request can be taken at
// the earliest in the same cycle as the previous result appears.
// The result goes into an output register; the next command is taken while it
// waits. If rsp stalls, a finished result is held until the register is free.
// Reset clears the entry count and control state; RAM contents are never read
// before being written, so the RAM needs no clearing.
module delayed_event_timer_table #(
    parameter int MAX_EVENTS = dett_pkg::MAX_EVENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    dett_req_if.sink          req,
    dett_rsp_if.source        rsp
);

    localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int CW = $clog2(MAX_EVENTS + 1);
    localparam int EW = $bits(dett_pkg::entry_t);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    logic          rsp_valid_reg, rsp_valid_next;

    dett_pkg::op_t                      op_reg, op_next;
    logic [dett_pkg::KIND_W-1:0]        kind_reg, kind_next;
    logic [dett_pkg::SESSION_W-1:0]     sess_reg, sess_next;
    logic [dett_pkg::DELAY_W-1:0]       delay_reg, delay_next;
    logic [dett_pkg::DELAY_W-1:0]       elapsed_reg, elapsed_next;
    logic [dett_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [dett_pkg::KIND_W-1:0]        fkind_reg, fkind_next;
    logic [dett_pkg::SESSION_W-1:0]     fsess_reg, fsess_next;
    logic [dett_pkg::STATUS_W-1:0]      rsp_status_reg, rsp_status_next;
    logic                               rsp_rv_reg, rsp_rv_next;
    logic [dett_pkg::KIND_W-1:0]        rsp_kind_reg, rsp_kind_next;
    logic [dett_pkg::SESSION_W-1:0]     rsp_sess_reg, rsp_sess_next;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    dett_pkg::entry_t  ram_wdata;
    logic [IW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata_raw;
    dett_pkg::entry_t  ram_rdata;
    dett_pkg::entry_t  walk_entry;
    logic              hit;
    logic              out_free;
    dett_pkg::op_t     op_in;

    dett_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EVENTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = dett_pkg::entry_t'(ram_rdata_raw);
    assign op_in     = dett_pkg::op_t'(req.operation);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign ram_raddr = rd_reg[IW-1:0];

    // Removal match for the entry coming out of the RAM
    always_comb
    begin
        hit = 1'b0;
        unique case (op_reg)
            dett_pkg::OP_RESCHEDULE:
                hit = (ram_rdata.session == sess_reg) && (ram_rdata.kind == kind_reg);
            dett_pkg::OP_CANCEL:
                hit = (ram_rdata.session == sess_reg);
            dett_pkg::OP_DEQUEUE:
                hit = (ram_rdata.delay == '0) && !found_reg;
            default:
                hit = 1'b0;
        endcase
    end

    // Tick saturates at zero; other walks write the entry back unchanged
    always_comb
    begin
        walk_entry = ram_rdata;
        if (op_reg == dett_pkg::OP_TICK)
        begin
            walk_entry.delay = (ram_rdata.delay > elapsed_reg) ?
                               (ram_rdata.delay - elapsed_reg) : '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        pend_next       = pend_reg;
        found_next      = found_reg;
        op_next         = op_reg;
        kind_next       = kind_reg;
        sess_next       = sess_reg;
        delay_next      = delay_reg;
        elapsed_next    = elapsed_reg;
        status_next     = status_reg;
        fkind_next      = fkind_reg;
        fsess_next      = fsess_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_rv_next     = rsp_rv_reg;
        rsp_kind_next   = rsp_kind_reg;
        rsp_sess_next   = rsp_sess_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = op_in;
                    kind_next    = req.event_kind;
                    sess_next    = req.session_number;
                    delay_next   = req.delay_amount;
                    elapsed_next = req.elapsed_amount;
                    found_next   = 1'b0;
                    fkind_next   = '0;
                    fsess_next   = '0;
                    rd_next      = '0;
                    wr_next      = '0;
                    pend_next    = 1'b0;
                    status_next  = dett_pkg::ST_OK;
                    unique case (op_in)
                        dett_pkg::OP_SCHEDULE:
                        begin
                            state_next = S_FINISH;
                            if (req.event_kind != dett_pkg::KIND_NONE &&
                                count_reg < CW'(MAX_EVENTS))
                            begin
                                ram_we            = 1'b1;
                                ram_waddr         = count_reg[IW-1:0];
                                ram_wdata.kind    = req.event_kind;
                                ram_wdata.session = req.session_number;
                                ram_wdata.delay   = req.delay_amount;
                                count_next        = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = dett_pkg::ST_REJECTED;
                            end
                        end
                        dett_pkg::OP_RESCHEDULE:
                        begin
                            if (req.event_kind == dett_pkg::KIND_NONE)
                            begin
                                status_next = dett_pkg::ST_REJECTED;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        dett_pkg::OP_CANCEL,
                        dett_pkg::OP_TICK,
                        dett_pkg::OP_DEQUEUE:
                            state_next = S_WALK;
                        default:
                        begin
                            status_next = dett_pkg::ST_REJECTED;
                            state_next  = S_FINISH;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // Entry read last cycle: keep it at the write pointer or drop it
                if (pend_reg)
                begin
                    if (!hit)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_reg[IW-1:0];
                        ram_wdata = walk_entry;
                        wr_next   = wr_reg + CW'(1);
                    end
                    else if (op_reg == dett_pkg::OP_DEQUEUE)
                    begin
                        found_next = 1'b1;
                        fkind_next = ram_rdata.kind;
                        fsess_next = ram_rdata.session;
                    end
                end

                if (rd_reg < count_reg)
                begin
                    rd_next   = rd_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_FINISH;
                        count_next = wr_reg;
                        if (op_reg == dett_pkg::OP_RESCHEDULE)
                        begin
                            if (wr_reg < CW'(MAX_EVENTS))
                            begin
                                ram_we            = 1'b1;
                                ram_waddr         = wr_reg[IW-1:0];
                                ram_wdata.kind    = kind_reg;
                                ram_wdata.session = sess_reg;
                                ram_wdata.delay   = delay_reg;
                                count_next        = wr_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = dett_pkg::ST_REJECTED;
                            end
                        end
                        else if (op_reg == dett_pkg::OP_DEQUEUE && !found_reg)
                        begin
                            status_next = dett_pkg::ST_NONE;
                        end
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_rv_next     = found_reg;
                    rsp_kind_next   = fkind_reg;
                    rsp_sess_next   = fsess_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        kind_reg       <= kind_next;
        sess_reg       <= sess_next;
        delay_reg      <= delay_next;
        elapsed_reg    <= elapsed_next;
        status_reg     <= status_next;
        fkind_reg      <= fkind_next;
        fsess_reg      <= fsess_next;
        rsp_status_reg <= rsp_status_next;
        rsp_rv_reg     <= rsp_rv_next;
        rsp_kind_reg   <= rsp_kind_next;
        rsp_sess_reg   <= rsp_sess_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.ready_valid   = rsp_rv_reg;
    assign rsp.ready_kind    = rsp_kind_reg;
    assign rsp.ready_session = rsp_sess_reg;

endmodule

/* rtl/core/dett_checker.sv */
// Port-level assertions for the timer table, bound to the top level.
module dett_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic [dett_pkg::STATUS_W-1:0]       rsp_status,
    input  logic                                rsp_ready_valid,
    input  logic [dett_pkg::KIND_W-1:0]         rsp_ready_kind,
    input  logic [dett_pkg::SESSION_W-1:0]      rsp_ready_session
);

    // Held response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
        $stable(rsp_ready_valid) && $stable(rsp_ready_kind) && $stable(rsp_ready_session))
        else $error("response changed while stalled");

    // A returned event always carries status ok
    a_ready_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready_valid |-> rsp_status == dett_pkg::ST_OK)
        else $error("returned event without ok status");

    // Without a returned event the event fields read zero
    a_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready_valid |-> rsp_ready_kind == '0 && rsp_ready_session == '0)
        else $error("event fields nonzero without returned event");

    // A dequeued event never has kind none
    a_kind_set: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready_valid |-> rsp_ready_kind != dett_pkg::KIND_NONE)
        else $error("returned event with kind none");

    // One command in work: no request taken right after another
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous in work");

endmodule

bind delayed_event_timer_table dett_checker u_dett_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_ready_valid   (rsp.ready_valid),
    .rsp_ready_kind    (rsp.ready_kind),
    .rsp_ready_session (rsp.ready_session)
);

/* tb/delayed_event_timer_table_tb.sv */
// Self-checking testbench for the delayed event timer table: directed rows, then random traffic.
module delayed_event_timer_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dett_pkg::*;

    localparam int TABLE_DEPTH       = MAX_EVENTS_DEF;
    localparam int RANDOM_ITEMS      = 1600;
    localparam int CALM_ITEMS        = 150;
    localparam int PHASE_ITEMS       = 150;
    localparam int HOLD_AT           = 500;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES      = 4 * (TABLE_DEPTH + 3);

    // operation codes the block does not define
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [KIND_W-1:0]    kind;
        logic [SESSION_W-1:0] session;
        logic [DELAY_W-1:0]   delay;
        logic [DELAY_W-1:0]   elapsed;
    } command_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 found;
        logic [KIND_W-1:0]    kind;
        logic [SESSION_W-1:0] session;
    } event_reply_t;

    typedef struct {
        command_t     cmd;
        int           reps;
        bit           typed;
        event_reply_t reply;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dett_req_if req_ch();
    dett_rsp_if rsp_ch();

    delayed_event_timer_table #(
        .MAX_EVENTS (TABLE_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    entry_t              timer_entries[$];
    event_reply_t        replies_due[$];
    plan_row_t           directed_plan[$];
    logic [SESSION_W-1:0] session_pool[4];
    event_reply_t        oldest_reply;

    int  fail_count     = 0;
    int  sent_count     = 0;
    int  reply_count    = 0;
    int  dequeued_count = 0;
    int  reject_count   = 0;
    int  full_rejects   = 0;
    int  total_items    = 0;
    bit  calm           = 1'b0;
    bit  long_hold_done = 1'b0;

    // ---------------- predictor ----------------

    function automatic logic [STATUS_W-1:0] append_entry(command_t c);
        entry_t e;
        if (c.kind == KIND_NONE)
            return ST_REJECTED;
        if (timer_entries.size() >= TABLE_DEPTH)
        begin
            full_rejects++;
            return ST_REJECTED;
        end
        e.kind    = c.kind;
        e.session = c.session;
        e.delay   = c.delay;
        timer_entries.push_back(e);
        return ST_OK;
    endfunction

    function automatic void drop_matching(bit match_kind, logic [KIND_W-1:0] kind,
                                          logic [SESSION_W-1:0] session);
        entry_t kept[$];
        foreach (timer_entries[i])
            if (!(timer_entries[i].session == session &&
                  (!match_kind || timer_entries[i].kind == kind)))
                kept.push_back(timer_entries[i]);
        timer_entries = kept;
    endfunction

    function automatic event_reply_t timer_table_step(command_t c);
        event_reply_t r;
        r = '{ST_OK, 1'b0, KIND_NONE, '0};
        case (c.op)
            OP_SCHEDULE:
                r.status = append_entry(c);
            OP_RESCHEDULE:
                if (c.kind == KIND_NONE)
                    r.status = ST_REJECTED;
                else
                begin
                    drop_matching(1'b1, c.kind, c.session);
                    r.status = append_entry(c);
                end
            OP_CANCEL:
                drop_matching(1'b0, KIND_NONE, c.session);
            OP_TICK:
                foreach (timer_entries[i])
                    timer_entries[i].delay = (timer_entries[i].delay > c.elapsed) ?
                                             timer_entries[i].delay - c.elapsed : '0;
            OP_DEQUEUE:
            begin
                r.status = ST_NONE;
                for (int i = 0; i < timer_entries.size(); i++)
                begin
                    if (timer_entries[i].delay == '0)
                    begin
                        r.status  = ST_OK;
                        r.found   = 1'b1;
                        r.kind    = timer_entries[i].kind;
                        r.session = timer_entries[i].session;
                        timer_entries.delete(i);
                        break;
                    end
                end
            end
            default:
                r.status = ST_REJECTED;
        endcase
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic void add_row(logic [OP_W-1:0] op, logic [KIND_W-1:0] kind,
                                    logic [SESSION_W-1:0] session, logic [DELAY_W-1:0] delay,
                                    logic [DELAY_W-1:0] elapsed, int reps, bit typed,
                                    logic [STATUS_W-1:0] st, logic rv,
                                    logic [KIND_W-1:0] rk, logic [SESSION_W-1:0] rs);
        plan_row_t row;
        row.cmd   = '{op, kind, session, delay, elapsed};
        row.reps  = reps;
        row.typed = typed;
        row.reply = '{st, rv, rk, rs};
        directed_plan.push_back(row);
    endfunction

    function automatic command_t random_command(bit fill_heavy);
        command_t c;
        int pick;
        c.kind    = ($urandom_range(0, 19) == 0) ? KIND_NONE
                                                 : KIND_W'($urandom_range(1, 15));
        c.session = ($urandom_range(0, 99) < 85) ? session_pool[$urandom_range(0, 3)]
                                                 : $urandom();
        case ($urandom_range(0, 9))
            7:       c.delay = '0;
            8:       c.delay = $urandom();
            9:       c.delay = '1;
            default: c.delay = $urandom_range(0, 12);
        endcase
        case ($urandom_range(0, 9))
            7:       c.elapsed = '0;
            8:       c.elapsed = $urandom();
            9:       c.elapsed = '1;
            default: c.elapsed = $urandom_range(0, 6);
        endcase
        pick = $urandom_range(0, 99);
        if (fill_heavy)
        begin
            if (pick < 45)      c.op = OP_SCHEDULE;
            else if (pick < 60) c.op = OP_RESCHEDULE;
            else if (pick < 65) c.op = OP_CANCEL;
            else if (pick < 80) c.op = OP_TICK;
            else if (pick < 97) c.op = OP_DEQUEUE;
            else                c.op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end
        else
        begin
            if (pick < 20)      c.op = OP_SCHEDULE;
            else if (pick < 30) c.op = OP_RESCHEDULE;
            else if (pick < 40) c.op = OP_CANCEL;
            else if (pick < 60) c.op = OP_TICK;
            else if (pick < 97) c.op = OP_DEQUEUE;
            else                c.op = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end
        return c;
    endfunction

    task automatic send_request(command_t c, bit typed, event_reply_t typed_reply);
        int gap;
        event_reply_t predicted;
        gap = 0;
        if (!calm && $urandom_range(0, 6) == 0)
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.operation      <= c.op;
        req_ch.event_kind     <= c.kind;
        req_ch.session_number <= c.session;
        req_ch.delay_amount   <= c.delay;
        req_ch.elapsed_amount <= c.elapsed;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = timer_table_step(c);
        replies_due.push_back(typed ? typed_reply : predicted);
        sent_count++;
        calm = (sent_count >= total_items - CALM_ITEMS);
    endtask

    initial
    begin
        command_t c;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.operation      <= OP_SCHEDULE;
        req_ch.event_kind     <= KIND_NONE;
        req_ch.session_number <= '0;
        req_ch.delay_amount   <= '0;
        req_ch.elapsed_amount <= '0;

        session_pool[0] = '0;
        session_pool[1] = '1;
        session_pool[2] = $urandom();
        session_pool[3] = $urandom();

        // empty table, kind none and unknown codes
        add_row(OP_DEQUEUE,    4'd0,  32'd0,        32'd0,  32'd0, 1, 1'b1,
                ST_NONE, 1'b0, KIND_NONE, '0);
        add_row(OP_SCHEDULE,   KIND_NONE, 32'd1,    32'd5,  32'd0, 1, 1'b1,
                ST_REJECTED, 1'b0, KIND_NONE, '0);
        add_row(OP_RESCHEDULE, KIND_NONE, 32'd1,    32'd5,  32'd0, 1, 1'b1,
                ST_REJECTED, 1'b0, KIND_NONE, '0);
        add_row(OP_UNUSED_LAST, 4'd3, 32'd1,        32'd5,  32'd9, 1, 1'b1,
                ST_REJECTED, 1'b0, KIND_NONE, '0);
        // field extremes
        add_row(OP_SCHEDULE,   4'd15, 32'hFFFF_FFFF, 32'd0, 32'd0, 1, 1'b1,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_SCHEDULE,   4'd1,  32'd0, 32'hFFFF_FFFF, 32'd0, 1, 1'b1,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_DEQUEUE,    4'd0,  32'd0,        32'd0,  32'd0, 1, 1'b1,
                ST_OK, 1'b1, 4'd15, 32'hFFFF_FFFF);
        add_row(OP_TICK,       4'd0,  32'd0, 32'd0, 32'hFFFF_FFFF, 1, 1'b1,
                ST_OK, 1'b0, KIND_NONE, '0);
        // fill to the top, then hit the full table
        add_row(OP_SCHEDULE,   4'd2,  32'd5,        32'd10, 32'd0, TABLE_DEPTH - 1, 1'b1,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_SCHEDULE,   4'd3,  32'd6,        32'd0,  32'd0, 1, 1'b1,
                ST_REJECTED, 1'b0, KIND_NONE, '0);
        add_row(OP_RESCHEDULE, 4'd9,  32'd7,        32'd0,  32'd0, 1, 1'b1,
                ST_REJECTED, 1'b0, KIND_NONE, '0);
        // removal frees room on a full table
        add_row(OP_RESCHEDULE, 4'd2,  32'd5,        32'd1,  32'd0, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_TICK,       4'd0,  32'd0,        32'd0,  32'd0, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_DEQUEUE,    4'd0,  32'd0,        32'd0,  32'd0, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_DEQUEUE,    4'd0,  32'd0,        32'd0,  32'd0, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_TICK,       4'd0,  32'd0,        32'd0,  32'd1, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        // cancel clears one session only
        add_row(OP_SCHEDULE,   4'd4,  32'd5,        32'd0,  32'd0, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_SCHEDULE,   4'd4,  32'd8,        32'd0,  32'd0, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_CANCEL,     4'd7,  32'd5,        32'd3,  32'd2, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_DEQUEUE,    4'd0,  32'd0,        32'd0,  32'd0, 1, 1'b0,
                ST_OK, 1'b0, KIND_NONE, '0);
        add_row(OP_DEQUEUE,    4'd0,  32'd0,        32'd0,  32'd0, 1, 1'b1,
                ST_NONE, 1'b0, KIND_NONE, '0);
        add_row(OP_UNUSED_FIRST, 4'd1, 32'd5,       32'd1,  32'd1, 1, 1'b1,
                ST_REJECTED, 1'b0, KIND_NONE, '0);

        foreach (directed_plan[i])
            total_items += directed_plan[i].reps;
        total_items += RANDOM_ITEMS;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            repeat (directed_plan[i].reps)
                send_request(directed_plan[i].cmd, directed_plan[i].typed,
                             directed_plan[i].reply);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            c = random_command(((n / PHASE_ITEMS) % 2) == 0);
            send_request(c, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands, checked %0d replies: %0d events dequeued, %0d rejected",
                 sent_count, reply_count, dequeued_count, reject_count);
        $display("Table-full rejections seen: %0d; long response stall applied: %0d",
                 full_rejects, long_hold_done);
        if (fail_count == 0 && replies_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ---------------- response side ----------------

    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_hold_done && sent_count >= HOLD_AT)
            begin
                // long stall so the table backs up into the request side
                rsp_ch.ready   <= 1'b0;
                long_hold_done = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("reply with no request outstanding: status %0d", rsp_ch.status);
                fail_count++;
            end
            else
            begin
                oldest_reply = replies_due.pop_front();
                reply_count++;
                if (oldest_reply.found)
                    dequeued_count++;
                if (oldest_reply.status == ST_REJECTED)
                    reject_count++;
                if (rsp_ch.status !== oldest_reply.status)
                begin
                    $error("status: expected %0d, got %0d", oldest_reply.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.ready_valid !== oldest_reply.found)
                begin
                    $error("ready_valid: expected %0d, got %0d",
                           oldest_reply.found, rsp_ch.ready_valid);
                    fail_count++;
                end
                if (rsp_ch.ready_kind !== oldest_reply.kind)
                begin
                    $error("ready_kind: expected %0d, got %0d",
                           oldest_reply.kind, rsp_ch.ready_kind);
                    fail_count++;
                end
                if (rsp_ch.ready_session !== oldest_reply.session)
                begin
                    $error("ready_session: expected %h, got %h",
                           oldest_reply.session, rsp_ch.ready_session);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* delayed_event_timer_table.f */
rtl/core/dett_pkg.sv
rtl/core/dett_req_if.sv
rtl/core/dett_rsp_if.sv
rtl/core/dett_ram.sv
rtl/core/delayed_event_timer_table.sv
rtl/core/dett_checker.sv
tb/delayed_event_timer_table_tb.sv
